>>> rtl/npst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package npst_pkg;
    localparam int NUM_INPUTS = 6;
    localparam int NUM_RELAYS = 4;
    localparam logic [2:0] MAX_RELAY_COUNT = 3'd4;
    localparam logic [7:0] CMD_ON = 8'h02;

    typedef enum logic [2:0] {
        MODE_INSERT  = 3'd0,
        MODE_HBEAT   = 3'd1,
        MODE_MISS    = 3'd2,
        MODE_QUERY   = 3'd3,
        MODE_FIND    = 3'd4,
        MODE_RELAY_W = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        EV_NOT_FOUND    = 4'd0,
        EV_JOIN         = 4'd1,
        EV_REPORT       = 4'd2,
        EV_HEARTBEAT    = 4'd3,
        EV_LEAVE        = 4'd4,
        EV_DISCOVERY    = 4'd5,
        EV_IO_CHANGE    = 4'd6,
        EV_RELAY_CHANGE = 4'd7,
        EV_REMOVED      = 4'd8,
        EV_MISS         = 4'd9,
        EV_FOUND        = 4'd10,
        EV_FULL         = 4'd11
    } t_event;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_DISPATCH, ST_JOIN, ST_REPORT, ST_INPUT,
        ST_RELAY, ST_WAIT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;      // capture input word
        logic       scan_clr;  // reset scan index and search results
        logic       scan_step; // examine one entry
        logic       do_insert;
        logic       do_hb;     // clear misses, store new enables/triggers/relays
        logic       do_miss;
        logic       do_wrelay;
        logic       ch_clr;
        logic       ch_step;
        logic       emit;      // load output register
        logic [3:0] ev;
        logic       ev_last;
        logic       use_ch;    // event carries channel and level
        logic       relay_ch;  // channel and level come from the relay write command
        logic       report;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        t_mode      mode;
        logic       scan_done;
        logic       hit;
        logic       free_found;
        logic       miss_over;
        logic       relay_diff;
        logic [2:0] ch;
        logic       in_evt;     // current input has an event
        logic       in_later;   // any input at or after ch+1 has an event
        logic       en_flip;    // enable of the current input changes
        logic       en_old;     // stored enable of the current input
        logic       rl_evt;
        logic       rl_later;
        logic       rl_any;     // any relay has an event
        logic       out_busy;
    } t_stat;
endpackage
`default_nettype wire

>>> rtl/npst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module npst_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [55:0]      i_word,
    input  wire logic [7:0]       i_miss_limit,
    input  wire npst_pkg::t_cmd   i_cmd,
    output npst_pkg::t_stat       o_stat,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [31:0]           o_data,
    output logic                  o_last,
    output logic [2:0]            o_rc
);
    import npst_pkg::*;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [7:0] r_addr [TABLE_DEPTH];
    logic [2:0] r_relays [TABLE_DEPTH];
    logic [5:0] r_en [TABLE_DEPTH];
    logic [5:0] r_tr [TABLE_DEPTH];
    logic [3:0] r_rb [TABLE_DEPTH];
    logic [7:0] r_miss [TABLE_DEPTH];

    logic [2:0] r_mode;
    logic [7:0] r_naddr, r_type, r_lo, r_hi, r_rel, r_wst;
    logic [1:0] r_rch;
    logic [CW-1:0] r_scan;
    logic r_hit, r_free;
    logic [IW-1:0] r_hidx, r_fidx;
    logic [2:0] r_ch;
    logic [5:0] r_cen, r_ctr;
    logic [3:0] r_crb;
    logic [2:0] r_crc;
    logic [7:0] r_cmiss;
    logic r_ovalid;
    logic [31:0] r_odata;
    logic [31:0] n_odata;
    logic r_olast;
    logic [2:0] r_orc;

    logic [5:0] fen, ftr;
    logic [3:0] frb;
    logic [IW-1:0] sidx;
    logic [5:0] ievt, ilater;
    logic [3:0] revt, rlater, rmask;
    logic [2:0] rc_sat;
    logic wbit, cur_in_evt;
    logic [3:0] nrb;
    logic [5:0] hb_tr;

    always_comb begin
        fen = {r_hi[3], r_hi[1], r_lo[7], r_lo[5], r_lo[3], r_lo[1]};
        ftr = {r_hi[2], r_hi[0], r_lo[6], r_lo[4], r_lo[2], r_lo[0]};
        frb = {r_rel[7], r_rel[5], r_rel[3], r_rel[1]};
        sidx = r_scan[IW-1:0];
        rmask = 4'((5'd1 << r_crc) - 5'd1);
        rc_sat = (r_type > 8'(MAX_RELAY_COUNT)) ? MAX_RELAY_COUNT : r_type[2:0];
        wbit = (r_wst == CMD_ON);
        for (int k = 0; k < NUM_INPUTS; k++)
            ievt[k] = (r_cen[k] != fen[k]) || (r_cen[k] && (r_ctr[k] != ftr[k]));
        for (int k = 0; k < NUM_RELAYS; k++)
            revt[k] = rmask[k] && (r_crb[k] != frb[k]);
        for (int k = 0; k < NUM_INPUTS; k++)
            ilater[k] = |(ievt >> (k + 1));
        for (int k = 0; k < NUM_RELAYS; k++)
            rlater[k] = |(revt >> (k + 1));
        cur_in_evt = ievt[r_ch];
        nrb = r_crb;
        nrb[r_rch] = wbit;
        hb_tr = (ftr & (r_cen | fen)) | (r_ctr & ~(r_cen | fen));
    end

    always_comb begin
        o_stat.mode       = t_mode'(r_mode);
        o_stat.scan_done  = (r_scan == CW'(TABLE_DEPTH));
        o_stat.hit        = r_hit;
        o_stat.free_found = r_free;
        o_stat.miss_over  = r_cmiss > i_miss_limit;
        o_stat.relay_diff = r_crb[r_rch] != wbit;
        o_stat.ch         = r_ch;
        o_stat.in_evt     = cur_in_evt;
        o_stat.in_later   = ilater[r_ch];
        o_stat.en_flip    = r_cen[r_ch] != fen[r_ch];
        o_stat.en_old     = r_cen[r_ch];
        o_stat.rl_evt     = revt[r_ch[1:0]];
        o_stat.rl_later   = rlater[r_ch[1:0]];
        o_stat.rl_any     = |revt;
        o_stat.out_busy   = r_ovalid && !i_ready;
    end

    always_comb begin
        n_odata       = '0;
        n_odata[3:0]  = i_cmd.ev;
        n_odata[11:4] = r_naddr;
        if (i_cmd.use_ch) begin
            n_odata[14:12] = i_cmd.relay_ch ? {1'b0, r_rch} : r_ch;
            n_odata[15]    = i_cmd.relay_ch ? wbit :
                             (i_cmd.ev == EV_RELAY_CHANGE ? frb[r_ch[1:0]] : ftr[r_ch]);
        end
        if (i_cmd.report) begin
            n_odata[21:16] = r_cen;
            n_odata[27:22] = r_ctr & r_cen;
            n_odata[31:28] = r_crb & rmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_word[2:0];
            r_naddr <= i_word[10:3];
            r_type  <= i_word[18:11];
            r_lo    <= i_word[26:19];
            r_hi    <= i_word[34:27];
            r_rel   <= i_word[42:35];
            r_rch   <= i_word[44:43];
            r_wst   <= i_word[52:45];
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
            r_hidx <= '0;
            r_fidx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + CW'(1);
            if (!r_hit && r_valid[sidx] && r_addr[sidx] == r_naddr) begin
                r_hidx  <= sidx;
                r_cen   <= r_en[sidx];
                r_ctr   <= r_tr[sidx];
                r_crb   <= r_rb[sidx];
                r_crc   <= r_relays[sidx];
                r_cmiss <= r_miss[sidx];
            end
            if (!r_free && !r_valid[sidx]) r_fidx <= sidx;
        end
        if (i_cmd.do_insert) begin
            r_addr[r_fidx]   <= r_naddr;
            r_relays[r_fidx] <= rc_sat;
            r_en[r_fidx]     <= fen;
            r_tr[r_fidx]     <= ftr;
            r_rb[r_fidx]     <= frb;
            r_miss[r_fidx]   <= '0;
            r_cen <= fen;
            r_ctr <= ftr;
            r_crb <= frb;
            r_crc <= rc_sat;
        end
        if (i_cmd.do_hb) begin
            r_miss[r_hidx] <= '0;
            r_en[r_hidx]   <= fen;
            r_tr[r_hidx]   <= hb_tr;
            r_rb[r_hidx]   <= (r_crb & ~rmask) | (frb & rmask);
        end
        if (i_cmd.do_miss && !(r_cmiss > i_miss_limit) && r_cmiss != 8'hFF)
            r_miss[r_hidx] <= r_cmiss + 8'd1;
        if (i_cmd.do_wrelay) r_rb[r_hidx] <= nrb;
        if (i_cmd.ch_clr) r_ch <= '0;
        else if (i_cmd.ch_step) r_ch <= r_ch + 3'd1;
        if (i_cmd.emit) begin
            r_olast <= i_cmd.ev_last;
            r_odata <= n_odata;
            r_orc   <= i_cmd.report ? r_crc : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_valid[sidx] && r_addr[sidx] == r_naddr) r_hit <= 1'b1;
                if (!r_valid[sidx]) r_free <= 1'b1;
            end
            if (i_cmd.do_insert) r_valid[r_fidx] <= 1'b1;
            if (i_cmd.do_miss && r_cmiss > i_miss_limit) r_valid[r_hidx] <= 1'b0;
            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_rc    = r_orc;
endmodule
`default_nettype wire

>>> rtl/npst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module npst_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire npst_pkg::t_stat i_stat,
    output npst_pkg::t_cmd      o_cmd
);
    import npst_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.ch_clr   = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.mode > MODE_RELAY_W) n_state = ST_IDLE;
                else if (i_stat.scan_done) n_state = ST_DISPATCH;
                else o_cmd.scan_step = 1'b1;
            end
            ST_DISPATCH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.ev_last = 1'b1;
                    n_state = ST_WAIT;
                    if (i_stat.mode == MODE_INSERT) begin
                        if (i_stat.free_found) begin
                            o_cmd.ev_last   = 1'b0;
                            o_cmd.ev        = EV_JOIN;
                            o_cmd.do_insert = 1'b1;
                            n_state = ST_REPORT;
                        end else o_cmd.ev = EV_FULL;
                    end else if (!i_stat.hit) begin
                        o_cmd.ev = EV_NOT_FOUND;
                    end else begin
                        case (i_stat.mode)
                            MODE_HBEAT: begin
                                o_cmd.ev      = EV_HEARTBEAT;
                                o_cmd.ev_last = !(i_stat.in_evt || i_stat.in_later ||
                                                  i_stat.rl_any);
                                o_cmd.ch_clr  = 1'b1;
                                n_state = ST_INPUT;
                            end
                            MODE_MISS: begin
                                o_cmd.do_miss = 1'b1;
                                o_cmd.ev = i_stat.miss_over ? EV_REMOVED : EV_MISS;
                            end
                            MODE_QUERY: begin
                                o_cmd.ev     = EV_REPORT;
                                o_cmd.report = 1'b1;
                            end
                            MODE_FIND: o_cmd.ev = EV_FOUND;
                            default: begin
                                o_cmd.do_wrelay = i_stat.relay_diff;
                                if (i_stat.relay_diff) begin
                                    o_cmd.ev       = EV_RELAY_CHANGE;
                                    o_cmd.use_ch   = 1'b1;
                                    o_cmd.relay_ch = 1'b1;
                                end else o_cmd.ev = EV_FOUND;
                            end
                        endcase
                    end
                end
            end
            ST_REPORT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev = EV_REPORT;
                    o_cmd.report = 1'b1;
                    o_cmd.ev_last = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_INPUT: begin
                if (i_stat.ch == 3'(NUM_INPUTS)) begin
                    o_cmd.ch_clr = 1'b1;
                    n_state = ST_RELAY;
                end else if (!i_stat.in_evt) begin
                    o_cmd.ch_step = 1'b1;
                end else if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.use_ch = 1'b1;
                    o_cmd.ch_step = 1'b1;
                    o_cmd.ev_last = !(i_stat.in_later || i_stat.rl_any);
                    if (i_stat.en_flip) o_cmd.ev = i_stat.en_old ? EV_LEAVE : EV_DISCOVERY;
                    else o_cmd.ev = EV_IO_CHANGE;
                end
            end
            ST_RELAY: begin
                if (i_stat.ch == 3'(NUM_RELAYS)) begin
                    o_cmd.do_hb = 1'b1;
                    n_state = ST_WAIT;
                end else if (!i_stat.rl_evt) begin
                    o_cmd.ch_step = 1'b1;
                end else if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.use_ch = 1'b1;
                    o_cmd.ch_step = 1'b1;
                    o_cmd.ev = EV_RELAY_CHANGE;
                    o_cmd.ev_last = !i_stat.rl_later;
                end
            end
            ST_WAIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/node_presence_status_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Words
// s_axis    in         one command word (mode, address, frame bytes)
// m_axis    out        one to eleven event words, tlast on the final one
// cfg       in         miss limit
// An accepted word is followed by a scan of all TABLE_DEPTH entries, a dispatch state
// and a closing wait state before the next word is taken; an insert adds a report
// state and a heartbeat walks six inputs and four relays. Unused modes go back to idle
// from the scan state. Reset is synchronous, active low, and empties the table. A
// waiting event that the output holds off stalls the sequence until the output is free.
module node_presence_status_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode[2:0], node_addr[10:3], type_byte[18:11], io_low_byte[26:19],
    // io_high_byte[34:27], relay_byte[42:35], relay_channel[44:43],
    // relay_cmd[52:45]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_res[3:0], event_addr[11:4], channel[14:12], level[15],
    // enable_mask[21:16], trigger_mask[27:22], relay_mask[31:28], relay_count[34:32]
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);
    import npst_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic [7:0] r_miss_limit;
    logic [31:0] dp_data;
    logic [2:0] dp_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_miss_limit <= 8'd5;
        else if (i_cfg_valid) r_miss_limit <= i_cfg_data;
    end
    assign o_cfg_ready = 1'b1;

    npst_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    npst_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_word(s_axis_tdata), .i_miss_limit(r_miss_limit),
        .i_cmd(cmd), .o_stat(stat), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_data(dp_data), .o_last(m_axis_tlast),
        .o_rc(dp_rc)
    );

    assign m_axis_tdata = {5'd0, dp_rc, dp_data};
endmodule
`default_nettype wire
